/* rtl/scs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the segment color statistics unit.
// No dependencies; every other file imports this package.
package scs_pkg;

    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 8;
    localparam int CNT_OUT_W = 17;
    localparam int RGB_W     = 3 * COLOR_W;
    localparam int DIST_W    = 18;

    localparam logic [COLOR_W-1:0]   COLOR_MAX       = 8'd255;
    localparam logic [COLOR_W-1:0]   COLOR_MIN       = 8'd0;
    localparam logic [CNT_OUT_W-1:0] MIN_COUNT_RESET = 17'd8;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        SEL_ROW,
        SEL_COL,
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } div_sel_t;

    typedef struct packed {
        logic     accum_en;
        logic     div_start;
        div_sel_t div_sel;
        logic     scan_start;
        logic     load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic scan_done;
        logic out_busy;
    } ctrl_status_t;

    typedef struct packed {
        logic [COORD_W-1:0]   center_row;
        logic [COORD_W-1:0]   center_col;
        logic [COLOR_W-1:0]   mean_red;
        logic [COLOR_W-1:0]   mean_green;
        logic [COLOR_W-1:0]   mean_blue;
        logic [COLOR_W-1:0]   main_red;
        logic [COLOR_W-1:0]   main_green;
        logic [COLOR_W-1:0]   main_blue;
        logic [CNT_OUT_W-1:0] pixel_count;
        logic                 stats_valid;
        logic                 keep_segment;
    } result_t;

    function automatic logic is_magenta(input logic [COLOR_W-1:0] r,
                                        input logic [COLOR_W-1:0] g,
                                        input logic [COLOR_W-1:0] b);
        return (r == COLOR_MAX) && (g == COLOR_MIN) && (b == COLOR_MAX);
    endfunction

endpackage

/* rtl/scs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, statistics output, config write.
// Depends on scs_pkg for field widths.
interface scs_pixel_if;
    import scs_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;

    modport source (output valid, pixel_row, pixel_col, red, green, blue, last_pixel,
                    input ready);
    modport sink (input valid, pixel_row, pixel_col, red, green, blue, last_pixel,
                  output ready);
endinterface

interface scs_stats_if;
    import scs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   center_row;
    logic [COORD_W-1:0]   center_col;
    logic [COLOR_W-1:0]   mean_red;
    logic [COLOR_W-1:0]   mean_green;
    logic [COLOR_W-1:0]   mean_blue;
    logic [COLOR_W-1:0]   main_red;
    logic [COLOR_W-1:0]   main_green;
    logic [COLOR_W-1:0]   main_blue;
    logic [CNT_OUT_W-1:0] pixel_count;
    logic                 stats_valid;
    logic                 keep_segment;

    modport source (output valid, center_row, center_col, mean_red, mean_green,
                    mean_blue, main_red, main_green, main_blue, pixel_count,
                    stats_valid, keep_segment,
                    input ready);
    modport sink (input valid, center_row, center_col, mean_red, mean_green,
                  mean_blue, main_red, main_green, main_blue, pixel_count,
                  stats_valid, keep_segment,
                  output ready);
endinterface

interface scs_cfg_if;
    import scs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CNT_OUT_W-1:0] min_pixel_count;

    modport source (output valid, min_pixel_count, input ready);
    modport sink (input valid, min_pixel_count, output ready);
endinterface

/* rtl/segment_color_statistics_unit.sv */
// Throughput: one pixel per cycle while a segment streams in; input is held off
// from the last pixel until the result is loaded.
// After the last pixel, five divisions run on one shared divider, then a scan
// start state, a store read for each of the N counted pixels, the compare
// pipeline and a load state; an empty segment goes straight to the load.
// Reset: asynchronous, active low; totals clear, threshold returns to 8.
`timescale 1ns / 1ps
// Top level: joins controller and datapath to the channel interfaces.
// Depends on scs_pkg, scs_if, scs_ctrl, scs_datapath.
module segment_color_statistics_unit #(
    parameter int MAX_PIXELS = 65536,
    parameter int COORD_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    scs_pixel_if.sink         pixels,
    scs_stats_if.source       stats,
    scs_cfg_if.sink           cfg
);
    import scs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    result_t      result;
    logic         in_ready;
    logic         out_valid;

    scs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_last  (pixels.last_pixel),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    scs_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pixel_row (pixels.pixel_row),
        .pixel_col (pixels.pixel_col),
        .red       (pixels.red),
        .green     (pixels.green),
        .blue      (pixels.blue),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.min_pixel_count),
        .out_ready (stats.ready),
        .out_valid (out_valid),
        .result    (result)
    );

    assign pixels.ready       = in_ready;
    assign cfg.ready          = 1'b1;
    assign stats.valid        = out_valid;
    assign stats.center_row   = result.center_row;
    assign stats.center_col   = result.center_col;
    assign stats.mean_red     = result.mean_red;
    assign stats.mean_green   = result.mean_green;
    assign stats.mean_blue    = result.mean_blue;
    assign stats.main_red     = result.main_red;
    assign stats.main_green   = result.main_green;
    assign stats.main_blue    = result.main_blue;
    assign stats.pixel_count  = result.pixel_count;
    assign stats.stats_valid  = result.stats_valid;
    assign stats.keep_segment = result.keep_segment;

`ifndef NO_ASSERTIONS
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accum_en, cmd.div_start, cmd.scan_start, cmd.load_result}))
        else $error("controller issued overlapping commands");

    a_load_shows_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> stats.valid)
        else $error("loaded result not presented");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result && status.count_zero |=> !stats.stats_valid && !stats.keep_segment)
        else $error("empty segment produced valid statistics");

    a_no_input_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !pixels.ready)
        else $error("input accepted during color scan");
`endif

endmodule

/* rtl/scs_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, COORD_W quotient bits.
// Depends on scs_pkg. Dividend must be below divisor * 2**COORD_W.
module scs_divider #(
    parameter int CNT_W = 17
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [scs_pkg::COORD_W+CNT_W-1:0]  dividend,
    input  logic [CNT_W-1:0]                   divisor,
    output logic                               done,
    output logic [scs_pkg::COORD_W-1:0]        quotient
);
    import scs_pkg::*;

    localparam int STEP_W = $clog2(COORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  div_reg;
    logic [COORD_W-1:0] low_reg;
    logic [COORD_W-1:0] low_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, low_reg[COORD_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        // shift quotient bits in behind the dividend bits
        low_next = {low_reg[COORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(COORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[COORD_W+CNT_W-1:COORD_W];
            low_reg <= dividend[COORD_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

/* rtl/scs_datapath.sv */
`timescale 1ns / 1ps
// Datapath: running totals, color store, mean divider, nearest-color scan
// and result register. Depends on scs_pkg and scs_divider.
module scs_datapath #(
    parameter int MAX_PIXELS = 65536,
    parameter int COORD_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scs_pkg::ctrl_cmd_t              cmd,
    output scs_pkg::ctrl_status_t           status,
    input  logic [scs_pkg::COORD_W-1:0]     pixel_row,
    input  logic [scs_pkg::COORD_W-1:0]     pixel_col,
    input  logic [scs_pkg::COLOR_W-1:0]     red,
    input  logic [scs_pkg::COLOR_W-1:0]     green,
    input  logic [scs_pkg::COLOR_W-1:0]     blue,
    input  logic                            cfg_valid,
    input  logic [scs_pkg::CNT_OUT_W-1:0]   cfg_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output scs_pkg::result_t                result
);
    import scs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int IDX_W  = $clog2(MAX_PIXELS);
    localparam int COLT_W = COLOR_W + CNT_W;
    localparam int CRDT_W = COORD_W + CNT_W;
    localparam int CMP_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam int CB_EFF = (COORD_BITS > COORD_W) ? COORD_W : COORD_BITS;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << CB_EFF) - 64'd1);

    function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    // configuration
    logic [CNT_OUT_W-1:0] min_count_reg;

    // accumulation
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CRDT_W-1:0] row_total_reg;
    logic [CRDT_W-1:0] col_total_reg;
    logic [COLT_W-1:0] red_total_reg;
    logic [COLT_W-1:0] green_total_reg;
    logic [COLT_W-1:0] blue_total_reg;
    logic [COORD_W-1:0] row_m;
    logic [COORD_W-1:0] col_m;
    logic               take;
    logic [RGB_W-1:0]   store_mem [MAX_PIXELS];

    // means
    logic [CRDT_W-1:0]  dividend;
    logic               div_done;
    logic [COORD_W-1:0] quotient;
    logic [COORD_W-1:0] mean_row_reg;
    logic [COORD_W-1:0] mean_col_reg;
    logic [COLOR_W-1:0] mean_red_reg;
    logic [COLOR_W-1:0] mean_green_reg;
    logic [COLOR_W-1:0] mean_blue_reg;

    // scan
    logic              scan_active_reg;
    logic [CNT_W-1:0]  scan_addr_reg;
    logic              scan_last;
    logic              p1_reg;
    logic              l1_reg;
    logic              p2_reg;
    logic              l2_reg;
    logic              scan_done_reg;
    logic [RGB_W-1:0]  rd_data_reg;
    logic [RGB_W-1:0]  cand_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] best_reg;
    logic [RGB_W-1:0]  best_color_reg;

    // result
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_count_reg <= MIN_COUNT_RESET;
        else if (cfg_valid)
            min_count_reg <= cfg_data;
    end

    assign row_m    = pixel_row & COORD_MASK;
    assign col_m    = pixel_col & COORD_MASK;
    // drop magenta pixels and anything past the store depth
    assign take     = cmd.accum_en && !is_magenta(red, green, blue)
                      && (cnt_reg < CNT_W'(MAX_PIXELS));
    assign cnt_next = cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            row_total_reg   <= '0;
            col_total_reg   <= '0;
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
        end
        else if (cmd.load_result)
        begin
            cnt_reg         <= '0;
            row_total_reg   <= '0;
            col_total_reg   <= '0;
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
        end
        else if (take)
        begin
            cnt_reg         <= cnt_next;
            row_total_reg   <= row_total_reg + CRDT_W'(row_m);
            col_total_reg   <= col_total_reg + CRDT_W'(col_m);
            red_total_reg   <= red_total_reg + COLT_W'(red);
            green_total_reg <= green_total_reg + COLT_W'(green);
            blue_total_reg  <= blue_total_reg + COLT_W'(blue);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            store_mem[cnt_reg[IDX_W-1:0]] <= {red, green, blue};
        if (scan_active_reg)
            rd_data_reg <= store_mem[scan_addr_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        case (cmd.div_sel)
            SEL_ROW:   dividend = row_total_reg;
            SEL_COL:   dividend = col_total_reg;
            SEL_RED:   dividend = CRDT_W'(red_total_reg);
            SEL_GREEN: dividend = CRDT_W'(green_total_reg);
            SEL_BLUE:  dividend = CRDT_W'(blue_total_reg);
            default:   dividend = '0;
        endcase
    end

    scs_divider #(
        .CNT_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (cmd.div_sel)
                SEL_ROW:   mean_row_reg   <= quotient;
                SEL_COL:   mean_col_reg   <= quotient;
                SEL_RED:   mean_red_reg   <= quotient[COLOR_W-1:0];
                SEL_GREEN: mean_green_reg <= quotient[COLOR_W-1:0];
                SEL_BLUE:  mean_blue_reg  <= quotient[COLOR_W-1:0];
                default:   mean_row_reg   <= mean_row_reg;
            endcase
        end
    end

    // scan: read, distance, compare; earliest entry wins a tie
    assign scan_last = (scan_addr_reg == cnt_reg - 1'b1);

    always_comb
    begin
        dist_next = DIST_W'(sq_diff(rd_data_reg[3*COLOR_W-1:2*COLOR_W], mean_red_reg))
                  + DIST_W'(sq_diff(rd_data_reg[2*COLOR_W-1:COLOR_W], mean_green_reg))
                  + DIST_W'(sq_diff(rd_data_reg[COLOR_W-1:0], mean_blue_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_active_reg <= 1'b0;
            scan_addr_reg   <= '0;
            p1_reg          <= 1'b0;
            l1_reg          <= 1'b0;
            p2_reg          <= 1'b0;
            l2_reg          <= 1'b0;
            scan_done_reg   <= 1'b0;
        end
        else
        begin
            p1_reg        <= scan_active_reg;
            l1_reg        <= scan_active_reg && scan_last;
            p2_reg        <= p1_reg;
            l2_reg        <= l1_reg;
            scan_done_reg <= p2_reg && l2_reg;
            if (cmd.scan_start)
            begin
                scan_active_reg <= 1'b1;
                scan_addr_reg   <= '0;
            end
            else if (scan_active_reg)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                if (scan_last)
                    scan_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_reg)
        begin
            dist_reg <= dist_next;
            cand_reg <= rd_data_reg;
        end
        if (cmd.scan_start)
        begin
            best_reg       <= '1;
            best_color_reg <= '0;
        end
        else if (p2_reg && (dist_reg < best_reg))
        begin
            best_reg       <= dist_reg;
            best_color_reg <= cand_reg;
        end
    end

    always_comb
    begin
        result_next = '0;
        if (cnt_reg != '0)
        begin
            result_next.center_row   = mean_row_reg;
            result_next.center_col   = mean_col_reg;
            result_next.mean_red     = mean_red_reg;
            result_next.mean_green   = mean_green_reg;
            result_next.mean_blue    = mean_blue_reg;
            result_next.main_red     = best_color_reg[3*COLOR_W-1:2*COLOR_W];
            result_next.main_green   = best_color_reg[2*COLOR_W-1:COLOR_W];
            result_next.main_blue    = best_color_reg[COLOR_W-1:0];
            result_next.pixel_count  = CNT_OUT_W'(cnt_reg);
            result_next.stats_valid  = 1'b1;
            result_next.keep_segment = (CMP_W'(cnt_reg) > CMP_W'(min_count_reg))
                && !is_magenta(best_color_reg[3*COLOR_W-1:2*COLOR_W],
                               best_color_reg[2*COLOR_W-1:COLOR_W],
                               best_color_reg[COLOR_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
            result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign result            = result_reg;
    assign status.count_zero = (cnt_reg == '0);
    assign status.div_done   = div_done;
    assign status.scan_done  = scan_done_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule

/* rtl/scs_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences accumulation, the five mean divisions, the color scan
// and the result hand-off. Depends on scs_pkg.
module scs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output scs_pkg::ctrl_cmd_t    cmd,
    input  scs_pkg::ctrl_status_t status
);
    import scs_pkg::*;

    state_t   state_reg;
    state_t   state_next;
    div_sel_t div_sel_reg;
    div_sel_t div_sel_next;
    logic     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCUM;
            div_sel_reg <= SEL_ROW;
        end
        else
        begin
            state_reg   <= state_next;
            div_sel_reg <= div_sel_next;
        end
    end

    assign accept = in_valid && (state_reg == ST_ACCUM);

    always_comb
    begin
        state_next      = state_reg;
        div_sel_next    = div_sel_reg;
        in_ready        = 1'b0;
        cmd.accum_en    = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.div_sel     = div_sel_reg;
        cmd.scan_start  = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready     = 1'b1;
                cmd.accum_en = accept;
                if (accept && in_last)
                    state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                // an empty segment skips straight to the zero result
                if (status.count_zero)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    case (div_sel_reg)
                        SEL_ROW:
                        begin
                            div_sel_next = SEL_COL;
                            state_next   = ST_DIV_START;
                        end
                        SEL_COL:
                        begin
                            div_sel_next = SEL_RED;
                            state_next   = ST_DIV_START;
                        end
                        SEL_RED:
                        begin
                            div_sel_next = SEL_GREEN;
                            state_next   = ST_DIV_START;
                        end
                        SEL_GREEN:
                        begin
                            div_sel_next = SEL_BLUE;
                            state_next   = ST_DIV_START;
                        end
                        default:
                        begin
                            div_sel_next = SEL_ROW;
                            state_next   = ST_SCAN_START;
                        end
                    endcase
                end
            end
            ST_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (status.scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the item
                if (!status.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule
